// File: design/nearest_neighbor_point_tracker_top_assert.svh
// Assertion macros for the nearest neighbor point tracker.
// Included by the top level; depends on nothing else.
`ifndef NEAREST_NEIGHBOR_POINT_TRACKER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_POINT_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NNPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define NNPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/nnpt_pkg.sv
// Shared types and constants of the nearest neighbor point tracker.
// No dependencies.
package nnpt_pkg;

   localparam int COORD_W = 16;
   localparam int ID_W    = 16;
   localparam int MISS_W  = 8;
   localparam int GAIN_W  = 17;
   localparam int DIST_W  = 2 * COORD_W + 1;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_DISTANCE  = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_ONE        = 17'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET      = 17'd32768;
   localparam logic [MISS_W-1:0] MISS_LIMIT_RESET = 8'd5;
   localparam logic [COORD_W-1:0] GATE_RESET     = 16'd320;
   localparam logic [MISS_W-1:0] MISS_MAX        = 8'd255;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [MISS_W-1:0]  miss;
   } track_entry_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   // status of the distance pipeline
   typedef struct packed {
      logic valid;
      logic busy;
   } dist_status_type;

endpackage

// File: design/nnpt_if.sv
// Channel interfaces of the nearest neighbor point tracker.
// No dependencies.
interface nnpt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] point_x;
   logic [15:0] point_y;
   logic        has_point;
   logic        end_of_frame;
   modport source(output valid, point_x, point_y, has_point, end_of_frame, input ready);
   modport sink(input valid, point_x, point_y, has_point, end_of_frame, output ready);
endinterface

interface nnpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] track_id;
   logic [15:0] track_x;
   logic [15:0] track_y;
   logic [7:0]  missed_frames;
   logic        list_empty;
   logic        last_track;
   logic        capacity_dropped;
   modport source(output valid, track_id, track_x, track_y, missed_frames, list_empty,
                  last_track, capacity_dropped, input ready);
   modport sink(input valid, track_id, track_x, track_y, missed_frames, list_empty,
                last_track, capacity_dropped, output ready);
endinterface

interface nnpt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [16:0] wdata;
   modport source(output valid, reg_index, wdata, input ready);
   modport sink(input valid, reg_index, wdata, output ready);
endinterface

// File: design/nnpt_dist.sv
// Two-stage squared distance pipeline with a tag carried alongside.
// Depends on nnpt_pkg.
module nnpt_dist #(
   parameter int TAG_W = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [nnpt_pkg::COORD_W-1:0] ax,
   input  logic [nnpt_pkg::COORD_W-1:0] ay,
   input  logic [nnpt_pkg::COORD_W-1:0] bx,
   input  logic [nnpt_pkg::COORD_W-1:0] by,
   input  logic [TAG_W-1:0]             in_tag,
   output nnpt_pkg::dist_status_type    status,
   output logic [nnpt_pkg::DIST_W-1:0]  out_dist,
   output logic [TAG_W-1:0]             out_tag
);
   import nnpt_pkg::*;

   logic [COORD_W-1:0]   dx, dy;
   logic [2*COORD_W-1:0] sqx_ff, sqy_ff;
   logic                 v1_ff, v2_ff;
   logic [TAG_W-1:0]     tag1_ff, tag2_ff;
   logic [DIST_W-1:0]    dist_ff;

   // absolute differences
   assign dx = (ax > bx) ? (ax - bx) : (bx - ax);
   assign dy = (ay > by) ? (ay - by) : (by - ay);

   // stage 1: squares, stage 2: sum
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      sqx_ff  <= dx * dx;
      sqy_ff  <= dy * dy;
      tag1_ff <= in_tag;
      dist_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      tag2_ff <= tag1_ff;
   end

   assign status.valid = v2_ff;
   assign status.busy  = v1_ff | v2_ff;
   assign out_dist     = dist_ff;
   assign out_tag      = tag2_ff;

endmodule

// File: design/nearest_neighbor_point_tracker_top.sv
// Top level of the nearest neighbor point tracker: sequencer, target and point memories.
// Depends on nnpt_pkg, nnpt_if, nnpt_dist and nearest_neighbor_point_tracker_top_assert.svh.
//
//   channel   dir  handshake      word
//   req_bus   in   valid/ready    point_x, point_y, has_point, end_of_frame
//   rsp_bus   out  valid/ready    track_id, track_x, track_y, missed_frames, flags
//   csr_bus   in   valid/ready    reg_index, wdata (always ready)
//
// A word without end_of_frame is taken while idle. At a frame end each prior target
// scans all buffered points through the single read port of the point memory.
// Reset is synchronous and clears control state only; memories are not cleared.
// A stalled result word holds; no request is taken until the frame is emitted.
module nearest_neighbor_point_tracker_top #(
   parameter int MAX_TARGETS = 32,
   parameter int MAX_POINTS  = 32
) (
   input logic         clock,
   input logic         reset,
   nnpt_req_if.sink    req_bus,
   nnpt_rsp_if.source  rsp_bus,
   nnpt_csr_if.sink    csr_bus
);
   import nnpt_pkg::*;

   localparam int TIDX_W = $clog2(MAX_TARGETS);
   localparam int TCNT_W = $clog2(MAX_TARGETS + 1);
   localparam int PIDX_W = $clog2(MAX_POINTS);
   localparam int PCNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [TCNT_W-1:0] TCNT_MAX = TCNT_W'(MAX_TARGETS);
   localparam logic [PCNT_W-1:0] PCNT_MAX = PCNT_W'(MAX_POINTS);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_T_READ    = 11'b000_0000_0010,
      ST_T_WAIT    = 11'b000_0000_0100,
      ST_SCAN      = 11'b000_0000_1000,
      ST_MULT      = 11'b000_0001_0000,
      ST_WRITE     = 11'b000_0010_0000,
      ST_NEW_READ  = 11'b000_0100_0000,
      ST_NEW_WAIT  = 11'b000_1000_0000,
      ST_EMIT_READ = 11'b001_0000_0000,
      ST_EMIT_WAIT = 11'b010_0000_0000,
      ST_RSP       = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic [PIDX_W-1:0] idx;
      point_type         pt;
   } scan_tag_type;

   // configuration
   logic [GAIN_W-1:0]    gain_ff;
   logic [MISS_W-1:0]    miss_limit_ff;
   logic [COORD_W-1:0]   gate_ff;
   logic [2*COORD_W-1:0] gate_sq_ff;

   // control
   state_type            state_ff;
   logic [TCNT_W-1:0]    track_count_ff;   // also the compaction write pointer
   logic [TCNT_W-1:0]    old_count_ff;
   logic [TCNT_W-1:0]    t_ff;             // target index, also emit index
   logic [PCNT_W-1:0]    point_count_ff;
   logic [PCNT_W-1:0]    p_ff;
   logic [ID_W-1:0]      next_id_ff;
   logic                 ovf_ff;
   logic [MAX_POINTS-1:0] near_ff;
   logic                 issue_v_ff;
   logic [PIDX_W-1:0]    issue_idx_ff;

   // current target and best match
   track_entry_type      cur_ff;
   logic                 found_ff;
   logic [DIST_W-1:0]    best_ff;
   point_type            best_pt_ff;
   logic                 hit_ff;
   logic [GAIN_W+COORD_W-1:0] prod_ox_ff, prod_mx_ff, prod_oy_ff, prod_my_ff;

   // memories
   track_entry_type      trk_mem [MAX_TARGETS];
   track_entry_type      trk_rdata_ff;
   point_type            pt_mem [MAX_POINTS];
   point_type            pt_rdata_ff;

   logic                 trk_rd_en, trk_we, pt_rd_en;
   logic [TIDX_W-1:0]    trk_rd_addr;
   track_entry_type      trk_wdata;
   logic [PIDX_W-1:0]    pt_rd_addr;

   // result register
   logic                 rsp_valid_ff;
   track_entry_type      rsp_entry_ff;
   logic                 rsp_empty_ff, rsp_last_ff, rsp_drop_ff;

   // scan path
   logic                 issue;
   dist_status_type      dist_st;
   logic [DIST_W-1:0]    dist_val;
   scan_tag_type         tag_in, tag_out;
   logic                 req_acc, rsp_acc;
   logic                 better;

   // write-back values
   logic [GAIN_W+COORD_W:0] sum_x, sum_y;
   logic [COORD_W-1:0]   new_x, new_y;
   logic [MISS_W-1:0]    new_miss;
   logic                 keep;

   assign req_acc = req_bus.valid & req_bus.ready;
   assign rsp_acc = rsp_valid_ff & rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         miss_limit_ff <= MISS_LIMIT_RESET;
         gate_ff       <= GATE_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_SMOOTHING_GAIN: gain_ff <= (csr_bus.wdata > GAIN_ONE) ? GAIN_ONE : csr_bus.wdata;
            CSR_MISS_LIMIT:     miss_limit_ff <= csr_bus.wdata[MISS_W-1:0];
            CSR_GATE_DISTANCE:  gate_ff <= csr_bus.wdata[COORD_W-1:0];
            default: ;
         endcase
      end
      gate_sq_ff <= gate_ff * gate_ff;
   end

   // scan issue: one point read per cycle
   assign issue  = (state_ff == ST_SCAN) && (p_ff < point_count_ff);
   assign tag_in = '{idx: issue_idx_ff, pt: pt_rdata_ff};

   nnpt_dist #(
      .TAG_W($bits(scan_tag_type))
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (issue_v_ff),
      .ax       (cur_ff.x),
      .ay       (cur_ff.y),
      .bx       (pt_rdata_ff.x),
      .by       (pt_rdata_ff.y),
      .in_tag   (tag_in),
      .status   (dist_st),
      .out_dist (dist_val),
      .out_tag  (tag_out)
   );

   assign better = !found_ff || (dist_val < best_ff);

   // memory port selection
   always_comb begin
      trk_rd_en   = 1'b0;
      trk_rd_addr = t_ff[TIDX_W-1:0];
      pt_rd_en    = 1'b0;
      pt_rd_addr  = p_ff[PIDX_W-1:0];
      trk_we      = 1'b0;
      trk_wdata   = '{id: cur_ff.id, x: new_x, y: new_y, miss: new_miss};
      case (state_ff)
         ST_T_READ, ST_EMIT_READ: trk_rd_en = 1'b1;
         ST_SCAN:     pt_rd_en = issue;
         ST_NEW_READ: pt_rd_en = (p_ff != point_count_ff) && !near_ff[p_ff[PIDX_W-1:0]];
         ST_WRITE:    trk_we = keep;
         ST_NEW_WAIT: begin
            trk_we    = (track_count_ff < TCNT_MAX);
            trk_wdata = '{id: next_id_ff, x: pt_rdata_ff.x, y: pt_rdata_ff.y, miss: '0};
         end
         default: ;
      endcase
   end

   // target memory
   always_ff @(posedge clock) begin
      if (trk_we) trk_mem[track_count_ff[TIDX_W-1:0]] <= trk_wdata;
      if (trk_rd_en) trk_rdata_ff <= trk_mem[trk_rd_addr];
   end

   // point buffer
   always_ff @(posedge clock) begin
      if (req_acc && req_bus.has_point && (point_count_ff < PCNT_MAX))
         pt_mem[point_count_ff[PIDX_W-1:0]] <= '{x: req_bus.point_x, y: req_bus.point_y};
      if (pt_rd_en) pt_rdata_ff <= pt_mem[pt_rd_addr];
   end

   // filter update and miss aging
   assign sum_x = {1'b0, prod_ox_ff} + {1'b0, prod_mx_ff} + (GAIN_W+COORD_W+1)'(32768);
   assign sum_y = {1'b0, prod_oy_ff} + {1'b0, prod_my_ff} + (GAIN_W+COORD_W+1)'(32768);
   assign new_x = hit_ff ? sum_x[2*COORD_W-1:COORD_W] : cur_ff.x;
   assign new_y = hit_ff ? sum_y[2*COORD_W-1:COORD_W] : cur_ff.y;
   assign new_miss = (hit_ff || cur_ff.miss == MISS_MAX) ? cur_ff.miss
                                                         : cur_ff.miss + MISS_W'(1);
   assign keep = (new_miss < miss_limit_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         track_count_ff <= '0;
         point_count_ff <= '0;
         next_id_ff     <= '0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         issue_v_ff     <= 1'b0;
         old_count_ff   <= '0;
         t_ff           <= '0;
         p_ff           <= '0;
         found_ff       <= 1'b0;
         near_ff        <= '0;
      end else begin
         issue_v_ff   <= issue;
         issue_idx_ff <= p_ff[PIDX_W-1:0];
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_bus.has_point) begin
                     if (point_count_ff < PCNT_MAX) point_count_ff <= point_count_ff + PCNT_W'(1);
                     else ovf_ff <= 1'b1;
                  end
                  if (req_bus.end_of_frame) begin
                     old_count_ff   <= track_count_ff;
                     track_count_ff <= '0;
                     t_ff           <= '0;
                     p_ff           <= '0;
                     near_ff        <= '0;
                     state_ff <= (track_count_ff != '0) ? ST_T_READ : ST_NEW_READ;
                  end
               end
            end
            ST_T_READ: state_ff <= ST_T_WAIT;
            ST_T_WAIT: begin
               cur_ff   <= trk_rdata_ff;
               found_ff <= 1'b0;
               p_ff     <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (issue) p_ff <= p_ff + PCNT_W'(1);
               if (dist_st.valid) begin
                  if (dist_val <= {1'b0, gate_sq_ff}) near_ff[tag_out.idx] <= 1'b1;
                  if (better) begin
                     found_ff   <= 1'b1;
                     best_ff    <= dist_val;
                     best_pt_ff <= tag_out.pt;
                  end
               end
               if (!issue && !issue_v_ff && !dist_st.busy) state_ff <= ST_MULT;
            end
            ST_MULT: begin
               hit_ff     <= found_ff && (best_ff <= {1'b0, gate_sq_ff});
               prod_ox_ff <= (GAIN_ONE - gain_ff) * cur_ff.x;
               prod_mx_ff <= gain_ff * best_pt_ff.x;
               prod_oy_ff <= (GAIN_ONE - gain_ff) * cur_ff.y;
               prod_my_ff <= gain_ff * best_pt_ff.y;
               state_ff   <= ST_WRITE;
            end
            ST_WRITE: begin
               if (keep) track_count_ff <= track_count_ff + TCNT_W'(1);
               t_ff <= t_ff + TCNT_W'(1);
               if (t_ff + TCNT_W'(1) < old_count_ff) begin
                  state_ff <= ST_T_READ;
               end else begin
                  p_ff     <= '0;
                  state_ff <= ST_NEW_READ;
               end
            end
            ST_NEW_READ: begin
               if (p_ff == point_count_ff) begin
                  t_ff <= '0;
                  if (track_count_ff == '0) begin
                     rsp_entry_ff <= '0;
                     rsp_empty_ff <= 1'b1;
                     rsp_last_ff  <= 1'b1;
                     rsp_drop_ff  <= ovf_ff;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RSP;
                  end else begin
                     state_ff <= ST_EMIT_READ;
                  end
               end else if (near_ff[p_ff[PIDX_W-1:0]]) begin
                  p_ff <= p_ff + PCNT_W'(1);
               end else begin
                  state_ff <= ST_NEW_WAIT;
               end
            end
            ST_NEW_WAIT: begin
               if (track_count_ff < TCNT_MAX) begin
                  track_count_ff <= track_count_ff + TCNT_W'(1);
                  next_id_ff     <= next_id_ff + ID_W'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
               p_ff     <= p_ff + PCNT_W'(1);
               state_ff <= ST_NEW_READ;
            end
            ST_EMIT_READ: state_ff <= ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
               rsp_entry_ff <= trk_rdata_ff;
               rsp_empty_ff <= 1'b0;
               rsp_last_ff  <= (t_ff + TCNT_W'(1) == track_count_ff);
               rsp_drop_ff  <= ovf_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_RSP;
            end
            ST_RSP: begin
               if (rsp_acc) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     point_count_ff <= '0;
                     ovf_ff         <= 1'b0;
                     state_ff       <= ST_IDLE;
                  end else begin
                     t_ff     <= t_ff + TCNT_W'(1);
                     state_ff <= ST_EMIT_READ;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result port
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.track_id         = rsp_entry_ff.id;
   assign rsp_bus.track_x          = rsp_entry_ff.x;
   assign rsp_bus.track_y          = rsp_entry_ff.y;
   assign rsp_bus.missed_frames    = rsp_entry_ff.miss;
   assign rsp_bus.list_empty       = rsp_empty_ff;
   assign rsp_bus.last_track       = rsp_last_ff;
   assign rsp_bus.capacity_dropped = rsp_drop_ff;

   // checks
`include "nearest_neighbor_point_tracker_top_assert.svh"

   `NNPT_ASSERT_NOW(a_rsp_only_in_rsp, clock, reset, rsp_valid_ff, state_ff == ST_RSP, "result word outside emit state")
   `NNPT_ASSERT_NOW(a_compact_behind, clock, reset, state_ff == ST_WRITE, track_count_ff <= t_ff, "compaction overtook read pointer")
   `NNPT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, track_count_ff <= TCNT_MAX && point_count_ff <= PCNT_MAX, "count above capacity")
   `NNPT_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_acc && rsp_last_ff, state_ff == ST_IDLE && point_count_ff == '0, "frame did not close")

endmodule

// File: tb/tb_nearest_neighbor_point_tracker_top.sv
// Self-checking testbench for nearest_neighbor_point_tracker_top.
// Depends on nnpt_pkg, the channel interfaces in nnpt_if and the tracker RTL.
// Words are predicted in a shadow tracker on acceptance and checked on the rsp channel.
`timescale 1ns / 1ps

module tb_nearest_neighbor_point_tracker_top;
   import nnpt_pkg::*;

   localparam int NUM_TARGETS   = 32;
   localparam int NUM_POINTS    = 32;
   localparam int STALL_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam int ITEM_GOAL     = 320;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               has_point;
      logic               end_of_frame;
   } meas_word_type;

   typedef struct {
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [MISS_W-1:0]  miss;
      logic               empty;
      logic               last;
      logic               dropped;
   } track_word_type;

   logic clock;
   logic reset;

   nnpt_req_if req_bus();
   nnpt_rsp_if rsp_bus();
   nnpt_csr_if csr_bus();

   nearest_neighbor_point_tracker_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow tracker state and registers
   logic [GAIN_W-1:0]  gain_q;
   logic [MISS_W-1:0]  limit_q;
   logic [COORD_W-1:0] gate_q;
   track_entry_type    trk [NUM_TARGETS];
   int                 trk_n;
   point_type          pts [NUM_POINTS];
   int                 pt_n;
   logic [ID_W-1:0]    id_next;
   logic               overflow_q;

   meas_word_type  meas_q[$];
   track_word_type track_q[$];
   meas_word_type  offered;

   int tx_idle;
   int rx_idle;
   int hold_req;
   int hold_seen;
   int hold_left;
   int stall_cnt;
   int err_cnt;
   int item_cnt;

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint unsigned sq_dist(logic [15:0] ax, logic [15:0] ay,
                                               logic [15:0] bx, logic [15:0] by);
      longint unsigned dx;
      longint unsigned dy;
      dx = (ax > bx) ? longint'(ax - bx) : longint'(bx - ax);
      dy = (ay > by) ? longint'(ay - by) : longint'(by - ay);
      return dx * dx + dy * dy;
   endfunction

   function automatic logic [15:0] smooth(logic [15:0] prev, logic [15:0] meas);
      longint unsigned acc;
      acc = (64'd65536 - longint'(gain_q)) * longint'(prev)
            + longint'(gain_q) * longint'(meas) + 64'd32768;
      return acc[31:16];
   endfunction

   // shadow tracker: buffer the point, run the frame update on end of frame
   function automatic void track_frame(meas_word_type w);
      logic [15:0]     old_x [NUM_TARGETS];
      logic [15:0]     old_y [NUM_TARGETS];
      int              old_n;
      int              kept;
      bit              found;
      bit              near_hit;
      longint unsigned best;
      longint unsigned d;
      longint unsigned gate_sq;
      int              best_i;
      logic [15:0]     nx;
      logic [15:0]     ny;
      logic [7:0]      miss;
      track_word_type  r;
      if (w.has_point) begin
         if (pt_n < NUM_POINTS) begin
            pts[pt_n].x = w.x;
            pts[pt_n].y = w.y;
            pt_n++;
         end else
            overflow_q = 1'b1;
      end
      if (!w.end_of_frame) return;
      gate_sq = longint'(gate_q) * longint'(gate_q);
      old_n = trk_n;
      for (int t = 0; t < old_n; t++) begin
         old_x[t] = trk[t].x;
         old_y[t] = trk[t].y;
      end
      // match or age prior targets, compacting the list
      kept = 0;
      for (int t = 0; t < old_n; t++) begin
         found = 0;
         best = 0;
         best_i = 0;
         for (int p = 0; p < pt_n; p++) begin
            d = sq_dist(old_x[t], old_y[t], pts[p].x, pts[p].y);
            if (!found || d < best) begin
               found = 1;
               best = d;
               best_i = p;
            end
         end
         nx = old_x[t];
         ny = old_y[t];
         miss = trk[t].miss;
         if (found && best <= gate_sq) begin
            nx = smooth(nx, pts[best_i].x);
            ny = smooth(ny, pts[best_i].y);
         end else if (miss != MISS_MAX)
            miss++;
         if (miss >= limit_q) continue;
         trk[kept].x = nx;
         trk[kept].y = ny;
         trk[kept].id = trk[t].id;
         trk[kept].miss = miss;
         kept++;
      end
      trk_n = kept;
      // new targets from points outside every prior gate
      for (int p = 0; p < pt_n; p++) begin
         near_hit = 0;
         for (int t = 0; t < old_n; t++)
            if (sq_dist(old_x[t], old_y[t], pts[p].x, pts[p].y) <= gate_sq) near_hit = 1;
         if (near_hit) continue;
         if (trk_n < NUM_TARGETS) begin
            trk[trk_n].x = pts[p].x;
            trk[trk_n].y = pts[p].y;
            trk[trk_n].id = id_next;
            trk[trk_n].miss = '0;
            trk_n++;
            id_next++;
         end else
            overflow_q = 1'b1;
      end
      if (trk_n == 0) begin
         r = '{id: '0, x: '0, y: '0, miss: '0, empty: 1'b1, last: 1'b1, dropped: overflow_q};
         track_q = {track_q, r};
      end else
         for (int t = 0; t < trk_n; t++) begin
            r = '{id: trk[t].id, x: trk[t].x, y: trk[t].y, miss: trk[t].miss, empty: 1'b0,
                  last: (t == trk_n - 1), dropped: overflow_q};
            track_q = {track_q, r};
         end
      pt_n = 0;
      overflow_q = 1'b0;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset)
         req_bus.valid <= 1'b0;
      else begin
         if (req_bus.valid && req_bus.ready) track_frame(offered);
         if (!req_bus.valid || req_bus.ready) begin
            if (meas_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
               offered = meas_q.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.point_x      <= offered.x;
               req_bus.point_y      <= offered.y;
               req_bus.has_point    <= offered.has_point;
               req_bus.end_of_frame <= offered.end_of_frame;
            end else
               req_bus.valid <= 1'b0;
         end
      end
   end

   // register writes seen by the shadow tracker
   always @(posedge clock) begin
      if (!reset && csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.reg_index)
            CSR_SMOOTHING_GAIN: gain_q <= (csr_bus.wdata > GAIN_ONE) ? GAIN_ONE : csr_bus.wdata;
            CSR_MISS_LIMIT:     limit_q <= csr_bus.wdata[MISS_W-1:0];
            CSR_GATE_DISTANCE:  gate_q <= csr_bus.wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // result receiver with random stalls and one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle);
   end

   // result checker
   always @(posedge clock) begin
      track_word_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (track_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) $display("ERROR: unexpected result word id=%0d", rsp_bus.track_id);
         end else begin
            e = track_q.pop_front();
            if (rsp_bus.track_id !== e.id || rsp_bus.track_x !== e.x
                || rsp_bus.track_y !== e.y || rsp_bus.missed_frames !== e.miss
                || rsp_bus.list_empty !== e.empty || rsp_bus.last_track !== e.last
                || rsp_bus.capacity_dropped !== e.dropped) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("ERROR: exp id=%0d x=%0d y=%0d miss=%0d empty=%b last=%b drop=%b,",
                           e.id, e.x, e.y, e.miss, e.empty, e.last, e.dropped,
                           " got id=%0d x=%0d y=%0d miss=%0d empty=%b last=%b drop=%b",
                           rsp_bus.track_id, rsp_bus.track_x, rsp_bus.track_y,
                           rsp_bus.missed_frames, rsp_bus.list_empty, rsp_bus.last_track,
                           rsp_bus.capacity_dropped);
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready) || reset)
         stall_cnt <= 0;
      else if (stall_cnt >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else
         stall_cnt <= stall_cnt + 1;
   end

   task automatic push_word(logic [15:0] x, logic [15:0] y, logic has, logic eof);
      meas_word_type w;
      w = '{x: x, y: y, has_point: has, end_of_frame: eof};
      meas_q = {meas_q, w};
      if (has || eof) item_cnt++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [16:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // wait until every word is taken and every result is back
   task automatic drain();
      @(posedge clock);
      while (meas_q.size() != 0 || req_bus.valid || track_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] jitter(logic [15:0] c, int span);
      int v;
      v = int'(c) + $urandom_range(2 * span) - span;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // one frame: points near current targets, fresh points, noise words
   task automatic rand_frame(int n_new, int near_pct);
      int span;
      span = (gate_q / 2 > 2000) ? 2000 : gate_q / 2;
      for (int t = 0; t < trk_n; t++) begin
         if ($urandom_range(99) < near_pct)
            push_word(jitter(trk[t].x, span), jitter(trk[t].y, span), 1'b1, 1'b0);
         if ($urandom_range(99) < 8) push_word(16'($urandom), 16'($urandom), 1'b0, 1'b0);
      end
      for (int i = 0; i < n_new; i++) push_word(16'($urandom), 16'($urandom), 1'b1, 1'b0);
      if ($urandom_range(1)) push_word(16'($urandom), 16'($urandom), 1'b1, 1'b1);
      else push_word(16'($urandom), 16'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.has_point = 1'b0;
      req_bus.end_of_frame = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = CSR_SMOOTHING_GAIN;
      csr_bus.wdata = '0;
      gain_q = GAIN_RESET;
      limit_q = MISS_LIMIT_RESET;
      gate_q = GATE_RESET;
      trk_n = 0;
      pt_n = 0;
      id_next = '0;
      overflow_q = 1'b0;
      hold_req = 0;
      hold_seen = 0;
      hold_left = 0;
      stall_cnt = 0;
      err_cnt = 0;
      item_cnt = 0;
      tx_idle = 27;
      rx_idle = 56;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, ignored word, corner points
      push_word(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
      push_word(16'h1234, 16'h4321, 1'b0, 1'b0);
      push_word(16'd0, 16'd0, 1'b1, 1'b0);
      push_word(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      push_word(16'd0, 16'hFFFF, 1'b1, 1'b0);
      push_word(16'hFFFF, 16'd0, 1'b1, 1'b1);
      // equidistant tie, then a point exactly on the gate
      push_word(16'd100, 16'd0, 1'b1, 1'b0);
      push_word(16'd0, 16'd100, 1'b1, 1'b0);
      push_word(16'd65215, 16'd65535, 1'b1, 1'b1);
      push_word(16'd4000, 16'd4000, 1'b1, 1'b1);
      // frames without points age targets out
      for (int i = 0; i < 6; i++) push_word('0, '0, 1'b0, 1'b1);
      drain();

      // long receiver hold-off while frames keep coming
      hold_req++;
      for (int f = 0; f < 6; f++) rand_frame($urandom_range(1, 4), 80);
      while (item_cnt < 110) rand_frame($urandom_range(0, 3), 75);
      drain();

      // capacity: no gate, targets never expire, overfull point buffer
      write_reg(CSR_SMOOTHING_GAIN, 17'h1FFFF);
      write_reg(CSR_MISS_LIMIT, 17'd255);
      write_reg(CSR_GATE_DISTANCE, 17'd0);
      for (int i = 0; i < 20; i++) push_word(16'($urandom), 16'($urandom), 1'b1, 1'b0);
      push_word('0, '0, 1'b0, 1'b1);
      for (int i = 0; i < 35; i++) push_word(16'($urandom), 16'($urandom), 1'b1, 1'b0);
      push_word('0, '0, 1'b0, 1'b1);
      drain();

      // swap idling; widest gate, gain zero, quick removal
      tx_idle = 56;
      rx_idle = 27;
      write_reg(CSR_SMOOTHING_GAIN, 17'd0);
      write_reg(CSR_MISS_LIMIT, 17'd1);
      write_reg(CSR_GATE_DISTANCE, 17'd65535);
      for (int f = 0; f < 4; f++) rand_frame($urandom_range(0, 3), 60);
      // sender pauses until every result is back
      while (meas_q.size() != 0 || req_bus.valid || track_q.size() != 0) @(posedge clock);
      write_reg(CSR_MISS_LIMIT, 17'd0);
      drain();
      push_word(16'd500, 16'd500, 1'b1, 1'b1);
      drain();
      write_reg(CSR_SMOOTHING_GAIN, 17'd65536);
      write_reg(CSR_MISS_LIMIT, 17'd3);
      write_reg(CSR_GATE_DISTANCE, 17'd1500);
      while (item_cnt < 220) rand_frame($urandom_range(0, 4), 75);
      drain();

      // no idling, mid-range settings
      tx_idle = 0;
      rx_idle = 0;
      write_reg(CSR_SMOOTHING_GAIN, 17'($urandom_range(1, 65535)));
      write_reg(CSR_MISS_LIMIT, 17'($urandom_range(2, 8)));
      write_reg(CSR_GATE_DISTANCE, 17'($urandom_range(200, 3000)));
      while (item_cnt < ITEM_GOAL) rand_frame($urandom_range(0, 4), 75);
      drain();

      if (err_cnt == 0 && track_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
